[hdl/smdsa_pkg.sv]
package smdsa_pkg;

  // Field widths of the channels
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned KIND_W      = 4;
  localparam int unsigned CODE_W      = 2;
  localparam int unsigned DEPTH_OUT_W = 6;
  localparam int unsigned BYTE_W      = 8;

  // Default number of stack entries
  localparam int unsigned STACK_DEPTH_DEF = 32;

  // Stack words
  typedef enum logic [KIND_W-1:0] {
    K_PUSH  = 4'd0,
    K_ADD   = 4'd1,
    K_SUB   = 4'd2,
    K_GT    = 4'd3,
    K_GE    = 4'd4,
    K_LT    = 4'd5,
    K_LE    = 4'd6,
    K_EQ    = 4'd7,
    K_NE    = 4'd8,
    K_DUP   = 4'd9,
    K_SWAP  = 4'd10,
    K_OVER  = 4'd11,
    K_DEPTH = 4'd12,
    K_PRINT = 4'd13,
    K_EMIT  = 4'd14
  } kind_t;

  // Output codes
  localparam logic [CODE_W-1:0] EK_NONE   = 2'd0;
  localparam logic [CODE_W-1:0] EK_NUMBER = 2'd1;
  localparam logic [CODE_W-1:0] EK_CHAR   = 2'd2;

  localparam logic [CODE_W-1:0] STAT_OK        = 2'd0;
  localparam logic [CODE_W-1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [CODE_W-1:0] STAT_OVERFLOW  = 2'd2;

  // Stack update requested by the decoder
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_GROW   = 2'd1,
    OP_SHRINK = 2'd2,
    OP_SWAP   = 2'd3
  } stk_op_t;

  typedef struct packed {
    stk_op_t           op;
    logic [DATA_W-1:0] value;
  } stk_ctrl_t;

  typedef struct packed {
    logic [CODE_W-1:0] emit_kind;
    logic [DATA_W-1:0] emit_value;
    logic [CODE_W-1:0] status;
  } alu_res_t;

  typedef struct packed {
    logic [CODE_W-1:0]      emit_kind;
    logic [DATA_W-1:0]      emit_value;
    logic [CODE_W-1:0]      status;
    logic [DEPTH_OUT_W-1:0] stack_depth;
  } out_item_t;

endpackage

[hdl/smdsa_if.sv]
interface smdsa_in_if import smdsa_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] literal;

  modport source(output valid, kind, literal, input ready);
  modport sink(input valid, kind, literal, output ready);
endinterface

interface smdsa_out_if import smdsa_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [CODE_W-1:0]        emit_kind;
  logic signed [DATA_W-1:0] emit_value;
  logic [CODE_W-1:0]        status;
  logic [DEPTH_OUT_W-1:0]   stack_depth;

  modport source(output valid, emit_kind, emit_value, status, stack_depth, input ready);
  modport sink(input valid, emit_kind, emit_value, status, stack_depth, output ready);
endinterface

[hdl/smdsa_alu.sv]
module smdsa_alu import smdsa_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned CW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic [KIND_W-1:0] kind,
  input  logic [DATA_W-1:0] literal,
  input  logic [CW-1:0]     cnt,
  input  logic [DATA_W-1:0] tos,
  input  logic [DATA_W-1:0] nos,
  output stk_ctrl_t         ctrl,
  output alu_res_t          res
);

  logic              need2;
  logic              need1;
  logic              grows;
  logic              underflow;
  logic              overflow;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] diff;
  logic              lt_ab;
  logic              gt_ab;
  logic              eq_ab;
  logic [DATA_W-1:0] op_val;
  stk_op_t           op_ok;
  logic [CODE_W-1:0] ek_ok;
  logic [DATA_W-1:0] ev_ok;

  // Stack depth requirements of each word
  always_comb begin
    need2 = 1'b0;
    need1 = 1'b0;
    grows = 1'b0;
    unique case (kind_t'(kind))
      K_ADD, K_SUB, K_GT, K_GE, K_LT, K_LE, K_EQ, K_NE, K_SWAP: need2 = 1'b1;
      K_OVER: begin
        need2 = 1'b1;
        grows = 1'b1;
      end
      K_DUP: begin
        need1 = 1'b1;
        grows = 1'b1;
      end
      K_PRINT, K_EMIT: need1 = 1'b1;
      K_PUSH, K_DEPTH: grows = 1'b1;
      default: ;
    endcase
  end

  assign underflow = (need2 && (32'(cnt) < 32'd2)) || (need1 && (32'(cnt) < 32'd1));
  assign overflow  = grows && (32'(cnt) >= STACK_DEPTH);

  // Arithmetic on second (a) and top (b)
  assign sum   = nos + tos;
  assign diff  = nos - tos;
  assign lt_ab = $signed(nos) < $signed(tos);
  assign gt_ab = $signed(tos) < $signed(nos);
  assign eq_ab = (nos == tos);

  // Result of a word that is allowed to execute
  always_comb begin
    op_val = '0;
    op_ok  = OP_HOLD;
    ek_ok  = EK_NONE;
    ev_ok  = '0;
    unique case (kind_t'(kind))
      K_PUSH: begin
        op_ok  = OP_GROW;
        op_val = literal;
      end
      K_ADD: begin
        op_ok  = OP_SHRINK;
        op_val = sum;
      end
      K_SUB: begin
        op_ok  = OP_SHRINK;
        op_val = diff;
      end
      K_GT: begin
        op_ok  = OP_SHRINK;
        op_val = DATA_W'(gt_ab);
      end
      K_GE: begin
        op_ok  = OP_SHRINK;
        op_val = DATA_W'(!lt_ab);
      end
      K_LT: begin
        op_ok  = OP_SHRINK;
        op_val = DATA_W'(lt_ab);
      end
      K_LE: begin
        op_ok  = OP_SHRINK;
        op_val = DATA_W'(!gt_ab);
      end
      K_EQ: begin
        op_ok  = OP_SHRINK;
        op_val = DATA_W'(eq_ab);
      end
      K_NE: begin
        op_ok  = OP_SHRINK;
        op_val = DATA_W'(!eq_ab);
      end
      K_DUP: begin
        op_ok  = OP_GROW;
        op_val = tos;
      end
      K_SWAP: op_ok = OP_SWAP;
      K_OVER: begin
        op_ok  = OP_GROW;
        op_val = nos;
      end
      K_DEPTH: begin
        op_ok  = OP_GROW;
        op_val = DATA_W'(cnt);
      end
      K_PRINT: begin
        op_ok  = OP_SHRINK;
        op_val = nos;
        ek_ok  = EK_NUMBER;
        ev_ok  = tos;
      end
      K_EMIT: begin
        op_ok  = OP_SHRINK;
        op_val = nos;
        ek_ok  = EK_CHAR;
        ev_ok  = DATA_W'(tos[BYTE_W-1:0]);
      end
      default: ;
    endcase
  end

  // Refused words leave the stack alone; underflow wins over overflow
  always_comb begin
    ctrl.value = op_val;
    priority if (underflow) begin
      ctrl.op        = OP_HOLD;
      res.emit_kind  = EK_NONE;
      res.emit_value = '0;
      res.status     = STAT_UNDERFLOW;
    end else if (overflow) begin
      ctrl.op        = OP_HOLD;
      res.emit_kind  = EK_NONE;
      res.emit_value = '0;
      res.status     = STAT_OVERFLOW;
    end else begin
      ctrl.op        = op_ok;
      res.emit_kind  = ek_ok;
      res.emit_value = ev_ok;
      res.status     = STAT_OK;
    end
  end

endmodule

[hdl/smdsa_stack.sv]
module smdsa_stack import smdsa_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned CW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  stk_ctrl_t         ctrl,
  output logic [CW-1:0]     cnt,
  output logic [CW-1:0]     cnt_nxt,
  output logic [DATA_W-1:0] tos,
  output logic [DATA_W-1:0] nos
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Entries below the top two live in the memory; third_r caches the
  // entry just under nos so a shrink can refill nos in the same cycle.
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [CW-1:0]     cnt_r;
  logic [DATA_W-1:0] tos_r;
  logic [DATA_W-1:0] nos_r;
  logic [DATA_W-1:0] third_r;
  logic [CW-1:0]     wr_pos;
  logic [CW-1:0]     rd_pos;
  logic              wr_en;
  logic              rd_en;

  assign wr_pos = cnt_r - CW'(2);
  assign rd_pos = cnt_r - CW'(4);
  assign wr_en  = en && (ctrl.op == OP_GROW) && (32'(cnt_r) >= 32'd2);
  assign rd_en  = en && (ctrl.op == OP_SHRINK) && (32'(cnt_r) >= 32'd4);

  // Entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (en) begin
      unique case (ctrl.op)
        OP_GROW:   cnt_nxt = cnt_r + CW'(1);
        OP_SHRINK: cnt_nxt = cnt_r - CW'(1);
        default:   cnt_nxt = cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Top-of-stack registers
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (ctrl.op)
        OP_GROW: begin
          tos_r <= ctrl.value;
          nos_r <= tos_r;
        end
        OP_SHRINK: begin
          tos_r <= ctrl.value;
          nos_r <= third_r;
        end
        OP_SWAP: begin
          tos_r <= nos_r;
          nos_r <= tos_r;
        end
        default: ;
      endcase
    end
  end

  // Spill memory and its registered read into third_r
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos[AW-1:0]] <= nos_r;
    end
    if (en && (ctrl.op == OP_GROW)) begin
      third_r <= nos_r;
    end else if (rd_en) begin
      third_r <= mem[rd_pos[AW-1:0]];
    end
  end

  assign cnt = cnt_r;
  assign tos = tos_r;
  assign nos = nos_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= STACK_DEPTH)
    else $error("stack count above depth");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(cnt_r))
    else $error("stack count moved without a transaction");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CW'(1))
           || (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("stack count changed by more than one");
`endif

endmodule

[hdl/stack_machine_data_stack_alu_unit.sv]
// Data stack unit of a small stack machine.
// in_ch carries one word per transaction (kind, literal); out_ch returns
// exactly one result per word: emit_kind, emit_value, status, stack_depth.
// Both channels use valid/ready; a transaction completes on a clock edge
// with valid and ready high.
// Each result is registered in the output buffer before it appears on out_ch.
// Throughput: one word per cycle while in_ch.ready is high. The top two
// entries sit in registers and a cached third entry is refilled from the
// spill memory by its registered read port, so no word waits for memory.
// A two-entry output buffer decouples the sides: with out_ch stalled, one
// more word is still taken, then in_ch.ready drops until a result leaves.
// Refused words (underflow, overflow) leave the stack as it was and only
// report the status.
// Reset (rst_n low, synchronous) empties the stack and the output buffer.
// No clearing pass is needed; stack contents are only read once written.
module stack_machine_data_stack_alu_unit import smdsa_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  smdsa_in_if.sink   in_ch,
  smdsa_out_if.source out_ch
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic              in_acc;
  logic              out_acc;
  stk_ctrl_t         ctrl;
  alu_res_t          res;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_nxt;
  logic [DATA_W-1:0] tos;
  logic [DATA_W-1:0] nos;
  logic [DATA_W-1:0] depth_ext;
  out_item_t         item;
  out_item_t         head_r;
  out_item_t         skid_r;
  logic              head_vld_r;
  logic              skid_vld_r;

  assign in_ch.ready = !skid_vld_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  smdsa_alu #(
    .STACK_DEPTH (STACK_DEPTH),
    .CW          (CW)
  ) u_alu (
    .kind    (in_ch.kind),
    .literal (in_ch.literal),
    .cnt     (cnt),
    .tos     (tos),
    .nos     (nos),
    .ctrl    (ctrl),
    .res     (res)
  );

  smdsa_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .CW          (CW)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (in_acc),
    .ctrl    (ctrl),
    .cnt     (cnt),
    .cnt_nxt (cnt_nxt),
    .tos     (tos),
    .nos     (nos)
  );

  // Result of the current transaction
  assign depth_ext        = DATA_W'(cnt_nxt);
  assign item.emit_kind   = res.emit_kind;
  assign item.emit_value  = res.emit_value;
  assign item.status      = res.status;
  assign item.stack_depth = depth_ext[DEPTH_OUT_W-1:0];

  // Two-entry output buffer: head drives the port, skid catches one more
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      priority if (!head_vld_r) begin
        head_vld_r <= in_acc;
      end else if (skid_vld_r) begin
        if (out_acc) begin
          skid_vld_r <= 1'b0;
        end
      end else begin
        if (out_acc && !in_acc) begin
          head_vld_r <= 1'b0;
        end else if (!out_acc && in_acc) begin
          skid_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (!head_vld_r || (out_acc && !skid_vld_r)) begin
      if (in_acc) begin
        head_r <= item;
      end
    end else if (out_acc && skid_vld_r) begin
      head_r <= skid_r;
    end else if (in_acc) begin
      skid_r <= item;
    end
  end

  assign out_ch.valid       = head_vld_r;
  assign out_ch.emit_kind   = head_r.emit_kind;
  assign out_ch.emit_value  = head_r.emit_value;
  assign out_ch.status      = head_r.status;
  assign out_ch.stack_depth = head_r.stack_depth;

`ifndef ASSERT_OFF
  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> head_vld_r)
    else $error("skid entry held while head is empty");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> head_vld_r)
    else $error("accepted transaction produced no result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(head_r)))
    else $error("stalled result changed or dropped");
`endif

endmodule
